@@ rtl/psec_pkg.sv @@
package psec_pkg;

    // fixed field widths of the result and read ports
    localparam int SLOT_W  = 5;
    localparam int OCC_W   = 6;
    localparam int COUNT_W = 32;
    localparam int KIND_W  = 2;

    // table depth, tied to the slot and occupancy field widths
    localparam int MAX_SENDERS = 32;

    // operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // signal kinds
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MISS = 4'b0100,
        S_READ = 4'b1000
    } t_state;

    // increment that sticks at the all-ones value
    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + t_count'(1);
    endfunction

endpackage

@@ rtl/psec_mem.sv @@
module psec_mem #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 86,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/per_sender_event_counter_table_top.sv @@
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+------------------------------------
// command  | in        | start high while busy low    | i_operation, i_sender_id,
//          |           |                              | i_signal_kind, i_read_index
// result   | out       | o_strobe, one cycle, no stall| o_slot, o_is_new, o_dropped_full,
//          |           |                              | o_done_res, o_entry_valid,
//          |           |                              | o_entry_id, o_entry_count_first,
//          |           |                              | o_entry_count_second, o_occupancy
//
// a record transaction scans the table one slot per cycle through the single read
// port of the entry memory: a sender found at slot k strobes when slot k is read back,
// a new or dropped sender after all used slots are read (via the miss state when empty)
// a read strobes after its entry is read back, or straight from idle if the index is unused
// busy falls in the strobe cycle, so the next transaction may start right then
// synchronous active-low reset clears occupancy, the stop flag and the sequencer;
// the memory is not cleared, only slots below occupancy are ever read
// the receiver cannot stall; every result is taken in its strobe cycle
module per_sender_event_counter_table_top #(
    parameter int ID_BITS     = 22
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic [ID_BITS-1:0]           i_sender_id,
    input  logic [psec_pkg::KIND_W-1:0]  i_signal_kind,
    input  logic [psec_pkg::SLOT_W-1:0]  i_read_index,
    output logic                         o_strobe,
    output logic [psec_pkg::SLOT_W-1:0]  o_slot,
    output logic                         o_is_new,
    output logic                         o_dropped_full,
    output logic                         o_done_res,
    output logic                         o_entry_valid,
    output logic [ID_BITS-1:0]           o_entry_id,
    output logic [psec_pkg::COUNT_W-1:0] o_entry_count_first,
    output logic [psec_pkg::COUNT_W-1:0] o_entry_count_second,
    output logic [psec_pkg::OCC_W-1:0]   o_occupancy
);

    // slot index width and occupancy counter width
    localparam int IDX_W  = (psec_pkg::MAX_SENDERS > 1) ? $clog2(psec_pkg::MAX_SENDERS) : 1;
    localparam int CNT_W  = $clog2(psec_pkg::MAX_SENDERS + 1);
    localparam int CMP_W  = (CNT_W > psec_pkg::SLOT_W) ? CNT_W : psec_pkg::SLOT_W;
    localparam int CW     = psec_pkg::COUNT_W;
    // entry layout: {sender id, first count, second count}
    localparam int ENT_W  = ID_BITS + 2 * CW;

    // sequencer state
    psec_pkg::t_state              r_state, n_state;
    logic [CNT_W-1:0]              r_used, n_used;
    logic                          r_stop, n_stop;
    logic [IDX_W-1:0]              r_scan, n_scan;
    logic [ID_BITS-1:0]            r_id, n_id;
    logic [psec_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [psec_pkg::SLOT_W-1:0]   r_ridx, n_ridx;

    // result registers
    logic                          r_strobe, n_strobe;
    logic [psec_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic                          r_is_new, n_is_new;
    logic                          r_dropped, n_dropped;
    logic                          r_done, n_done;
    logic                          r_valid, n_valid;
    logic [ID_BITS-1:0]            r_eid, n_eid;
    logic [CW-1:0]                 r_c1, n_c1;
    logic [CW-1:0]                 r_c2, n_c2;
    logic [psec_pkg::OCC_W-1:0]    r_occ, n_occ;

    // memory ports
    logic                          mem_wr_en;
    logic [IDX_W-1:0]              mem_wr_addr;
    logic [ENT_W-1:0]              mem_wr_data;
    logic                          mem_rd_en;
    logic [IDX_W-1:0]              mem_rd_addr;
    logic [ENT_W-1:0]              mem_rd_data;

    // fields of the entry read back
    logic [ID_BITS-1:0]            rd_id;
    logic [CW-1:0]                 rd_c1;
    logic [CW-1:0]                 rd_c2;
    logic                          room;

    assign rd_id = mem_rd_data[ENT_W-1 -: ID_BITS];
    assign rd_c1 = mem_rd_data[2*CW-1 -: CW];
    assign rd_c2 = mem_rd_data[CW-1:0];
    assign room  = (r_used < CNT_W'(psec_pkg::MAX_SENDERS));

    psec_mem #(
        .DEPTH  (psec_pkg::MAX_SENDERS),
        .WIDTH  (ENT_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_stop      = r_stop;
        n_scan      = r_scan;
        n_id        = r_id;
        n_kind      = r_kind;
        n_ridx      = r_ridx;
        n_strobe    = 1'b0;
        n_slot      = r_slot;
        n_is_new    = r_is_new;
        n_dropped   = r_dropped;
        n_done      = r_done;
        n_valid     = r_valid;
        n_eid       = r_eid;
        n_c1        = r_c1;
        n_c2        = r_c2;
        n_occ       = r_occ;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        case (r_state)
            psec_pkg::S_IDLE: begin
                if (start) begin
                    n_id   = i_sender_id;
                    n_kind = i_signal_kind;
                    n_ridx = i_read_index;
                    if (i_operation == psec_pkg::OP_READ) begin
                        if (CMP_W'(i_read_index) < CMP_W'(r_used)) begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = IDX_W'(i_read_index);
                            n_state     = psec_pkg::S_READ;
                        end else begin
                            // unused slot: answer at once with zero fields
                            n_strobe  = 1'b1;
                            n_slot    = i_read_index;
                            n_is_new  = 1'b0;
                            n_dropped = 1'b0;
                            n_done    = r_stop;
                            n_valid   = 1'b0;
                            n_eid     = '0;
                            n_c1      = '0;
                            n_c2      = '0;
                            n_occ     = psec_pkg::OCC_W'(r_used);
                        end
                    end else if (r_used == '0) begin
                        n_state = psec_pkg::S_MISS;
                    end else begin
                        // start the scan at slot zero
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        n_scan      = '0;
                        n_state     = psec_pkg::S_SCAN;
                    end
                end
            end

            psec_pkg::S_SCAN: begin
                if (rd_id == r_id) begin
                    // hit: update counters in place
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_scan;
                    mem_wr_data = {rd_id,
                        (r_kind == psec_pkg::KIND_FIRST)  ? psec_pkg::sat_inc(rd_c1) : rd_c1,
                        (r_kind == psec_pkg::KIND_SECOND) ? psec_pkg::sat_inc(rd_c2) : rd_c2};
                    if (r_kind == psec_pkg::KIND_STOP) begin
                        n_stop = 1'b1;
                    end
                    n_strobe  = 1'b1;
                    n_slot    = psec_pkg::SLOT_W'(r_scan);
                    n_is_new  = 1'b0;
                    n_dropped = 1'b0;
                    n_done    = (r_kind == psec_pkg::KIND_STOP) | r_stop;
                    n_valid   = 1'b0;
                    n_eid     = '0;
                    n_c1      = '0;
                    n_c2      = '0;
                    n_occ     = psec_pkg::OCC_W'(r_used);
                    n_state   = psec_pkg::S_IDLE;
                end else if ((CNT_W'(r_scan) + CNT_W'(1)) < r_used) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_scan + IDX_W'(1);
                    n_scan      = r_scan + IDX_W'(1);
                end else begin
                    n_state = psec_pkg::S_MISS;
                end
            end

            psec_pkg::S_MISS: begin
                // sender absent: append if there is room, else drop
                n_strobe  = 1'b1;
                n_valid   = 1'b0;
                n_eid     = '0;
                n_c1      = '0;
                n_c2      = '0;
                if (r_kind == psec_pkg::KIND_STOP) begin
                    n_stop = 1'b1;
                end
                n_done = (r_kind == psec_pkg::KIND_STOP) | r_stop;
                if (room) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = IDX_W'(r_used);
                    mem_wr_data = {r_id,
                        CW'(r_kind == psec_pkg::KIND_FIRST),
                        CW'(r_kind == psec_pkg::KIND_SECOND)};
                    n_used    = r_used + CNT_W'(1);
                    n_slot    = psec_pkg::SLOT_W'(r_used);
                    n_is_new  = 1'b1;
                    n_dropped = 1'b0;
                    n_occ     = psec_pkg::OCC_W'(r_used + CNT_W'(1));
                end else begin
                    n_slot    = '0;
                    n_is_new  = 1'b0;
                    n_dropped = 1'b1;
                    n_occ     = psec_pkg::OCC_W'(r_used);
                end
                n_state = psec_pkg::S_IDLE;
            end

            psec_pkg::S_READ: begin
                n_strobe  = 1'b1;
                n_slot    = r_ridx;
                n_is_new  = 1'b0;
                n_dropped = 1'b0;
                n_done    = r_stop;
                n_valid   = 1'b1;
                n_eid     = rd_id;
                n_c1      = rd_c1;
                n_c2      = rd_c2;
                n_occ     = psec_pkg::OCC_W'(r_used);
                n_state   = psec_pkg::S_IDLE;
            end

            default: begin
                n_state = psec_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= psec_pkg::S_IDLE;
            r_used   <= '0;
            r_stop   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_stop   <= n_stop;
            r_strobe <= n_strobe;
        end
    end

    // transaction and result payload
    always_ff @(posedge i_clk) begin
        r_scan    <= n_scan;
        r_id      <= n_id;
        r_kind    <= n_kind;
        r_ridx    <= n_ridx;
        r_slot    <= n_slot;
        r_is_new  <= n_is_new;
        r_dropped <= n_dropped;
        r_done    <= n_done;
        r_valid   <= n_valid;
        r_eid     <= n_eid;
        r_c1      <= n_c1;
        r_c2      <= n_c2;
        r_occ     <= n_occ;
    end

    assign busy                 = (r_state != psec_pkg::S_IDLE);
    assign o_strobe             = r_strobe;
    assign o_slot               = r_slot;
    assign o_is_new             = r_is_new;
    assign o_dropped_full       = r_dropped;
    assign o_done_res           = r_done;
    assign o_entry_valid        = r_valid;
    assign o_entry_id           = r_eid;
    assign o_entry_count_first  = r_c1;
    assign o_entry_count_second = r_c2;
    assign o_occupancy          = r_occ;

endmodule
